// ===== design/sha_pkg.sv =====
// ----------------------------------------------------------------------------
// sha_pkg
// shared types, constants and round functions for the sha-256 engine
// ----------------------------------------------------------------------------
`default_nettype none

package sha_pkg;

   localparam int unsigned WordBits   = 32;
   localparam int unsigned BlockWords = 16;
   localparam int unsigned HashWords  = 8;
   localparam int unsigned Rounds     = 64;

   localparam logic [7:0] PadByte = 8'h80;

   typedef logic [WordBits-1:0] word_type;

   // one 512-bit block as it travels between front and back
   typedef struct packed {
      logic [BlockWords-1:0][WordBits-1:0] words;
      logic                                is_final;
   } blk_entry_type;

   localparam logic [HashWords-1:0][WordBits-1:0] InitHash = {
      32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
      32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
   };

   localparam logic [Rounds-1:0][WordBits-1:0] RoundK = {
      32'hc67178f2, 32'hbef9a3f7, 32'ha4506ceb, 32'h90befffa,
      32'h8cc70208, 32'h84c87814, 32'h78a5636f, 32'h748f82ee,
      32'h682e6ff3, 32'h5b9cca4f, 32'h4ed8aa4a, 32'h391c0cb3,
      32'h34b0bcb5, 32'h2748774c, 32'h1e376c08, 32'h19a4c116,
      32'h106aa070, 32'hf40e3585, 32'hd6990624, 32'hd192e819,
      32'hc76c51a3, 32'hc24b8b70, 32'ha81a664b, 32'ha2bfe8a1,
      32'h92722c85, 32'h81c2c92e, 32'h766a0abb, 32'h650a7354,
      32'h53380d13, 32'h4d2c6dfc, 32'h2e1b2138, 32'h27b70a85,
      32'h14292967, 32'h06ca6351, 32'hd5a79147, 32'hc6e00bf3,
      32'hbf597fc7, 32'hb00327c8, 32'ha831c66d, 32'h983e5152,
      32'h76f988da, 32'h5cb0a9dc, 32'h4a7484aa, 32'h2de92c6f,
      32'h240ca1cc, 32'h0fc19dc6, 32'hefbe4786, 32'he49b69c1,
      32'hc19bf174, 32'h9bdc06a7, 32'h80deb1fe, 32'h72be5d74,
      32'h550c7dc3, 32'h243185be, 32'h12835b01, 32'hd807aa98,
      32'hab1c5ed5, 32'h923f82a4, 32'h59f111f1, 32'h3956c25b,
      32'he9b5dba5, 32'hb5c0fbcf, 32'h71374491, 32'h428a2f98
   };

   function automatic word_type rotr(input word_type v, input int unsigned s);
      rotr = (v >> s) | (v << (WordBits - s));
   endfunction

   function automatic word_type big_sigma0(input word_type v);
      big_sigma0 = rotr(v, 2) ^ rotr(v, 13) ^ rotr(v, 22);
   endfunction

   function automatic word_type big_sigma1(input word_type v);
      big_sigma1 = rotr(v, 6) ^ rotr(v, 11) ^ rotr(v, 25);
   endfunction

   function automatic word_type small_sigma0(input word_type v);
      small_sigma0 = rotr(v, 7) ^ rotr(v, 18) ^ (v >> 3);
   endfunction

   function automatic word_type small_sigma1(input word_type v);
      small_sigma1 = rotr(v, 17) ^ rotr(v, 19) ^ (v >> 10);
   endfunction

endpackage

`default_nettype wire

// ===== design/sha_front.sv =====
// ----------------------------------------------------------------------------
// sha_front
// packs message bytes into blocks, appends padding and length, and hands
// finished blocks to the queue
// ----------------------------------------------------------------------------
`default_nettype none

module sha_front
   import sha_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   input  wire logic [31:0]   req_data_word,
   input  wire logic [2:0]    req_byte_count,
   input  wire logic          req_last,
   output logic               push,
   output blk_entry_type      push_data,
   input  wire logic          full
);

   typedef enum logic [4:0] {
      F_IDLE = 5'b00001,
      F_BYTE = 5'b00010,
      F_PAD  = 5'b00100,
      F_LEN  = 5'b01000,
      F_PUSH = 5'b10000
   } front_state_type;

   front_state_type                     st_ff, st_in, ret_ff, ret_in;
   logic [BlockWords-1:0][WordBits-1:0] blk_ff, blk_in;
   logic [5:0]                          pos_ff, pos_in;
   logic [63:0]                         len_ff, len_in;
   logic [31:0]                         word_ff, word_in;
   logic [2:0]                          cnt_ff, cnt_in;
   logic [2:0]                          idx_ff, idx_in;
   logic                                last_ff, last_in;
   logic                                fin_ff, fin_in;
   logic [7:0]                          cur_byte;

   // byte of the held word picked by the byte index, msb first
   always_comb begin
      unique case (idx_ff[1:0])
         2'd0: cur_byte = word_ff[31:24];
         2'd1: cur_byte = word_ff[23:16];
         2'd2: cur_byte = word_ff[15:8];
         default: cur_byte = word_ff[7:0];
      endcase
   end

   // byte packing sequencer
   always_comb begin
      st_in   = st_ff;
      ret_in  = ret_ff;
      blk_in  = blk_ff;
      pos_in  = pos_ff;
      len_in  = len_ff;
      word_in = word_ff;
      cnt_in  = cnt_ff;
      idx_in  = idx_ff;
      last_in = last_ff;
      fin_in  = fin_ff;
      push    = 1'b0;
      unique case (st_ff)
         F_IDLE: begin
            if (req_valid) begin
               word_in = req_data_word;
               cnt_in  = (req_byte_count > 3'd4) ? 3'd4 : req_byte_count;
               idx_in  = 3'd0;
               last_in = req_last;
               st_in   = F_BYTE;
            end
         end
         F_BYTE: begin
            if (idx_ff == cnt_ff) begin
               st_in = last_ff ? F_PAD : F_IDLE;
            end else begin
               blk_in[pos_ff[5:2]][{~pos_ff[1:0], 3'b000} +: 8] = cur_byte;
               pos_in = pos_ff + 6'd1;
               idx_in = idx_ff + 3'd1;
               len_in = len_ff + 64'd8;
               if (pos_ff == 6'd63) begin
                  fin_in = 1'b0;
                  ret_in = F_BYTE;
                  st_in  = F_PUSH;
               end
            end
         end
         F_PAD: begin
            blk_in[pos_ff[5:2]][{~pos_ff[1:0], 3'b000} +: 8] = PadByte;
            pos_in = pos_ff + 6'd1;
            if (pos_ff <= 6'd55) begin
               st_in = F_LEN;
            end else begin
               fin_in = 1'b0;
               ret_in = F_LEN;
               st_in  = F_PUSH;
            end
         end
         F_LEN: begin
            blk_in[14] = len_ff[63:32];
            blk_in[15] = len_ff[31:0];
            fin_in     = 1'b1;
            ret_in     = F_IDLE;
            st_in      = F_PUSH;
         end
         F_PUSH: begin
            if (!full) begin
               push   = 1'b1;
               blk_in = '0;
               pos_in = 6'd0;
               if (fin_ff) len_in = 64'd0;
               st_in  = ret_ff;
            end
         end
         default: st_in = F_IDLE;
      endcase
   end

   assign req_stall          = (st_ff != F_IDLE);
   assign push_data.words    = blk_ff;
   assign push_data.is_final = fin_ff;

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= F_IDLE;
         ret_ff <= F_IDLE;
         blk_ff <= '0;
         pos_ff <= 6'd0;
         len_ff <= 64'd0;
         fin_ff <= 1'b0;
      end else begin
         st_ff  <= st_in;
         ret_ff <= ret_in;
         blk_ff <= blk_in;
         pos_ff <= pos_in;
         len_ff <= len_in;
         fin_ff <= fin_in;
      end
      word_ff <= word_in;
      cnt_ff  <= cnt_in;
      idx_ff  <= idx_in;
      last_ff <= last_in;
   end

endmodule

`default_nettype wire

// ===== design/sha_fifo.sv =====
// ----------------------------------------------------------------------------
// sha_fifo
// two-entry block queue between packing front and compression back
// ----------------------------------------------------------------------------
`default_nettype none

module sha_fifo
   import sha_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wire blk_entry_type push_data,
   output logic               full,
   input  wire logic          pop,
   output blk_entry_type      pop_data,
   output logic               empty
);

   blk_entry_type mem_ff [2];
   logic          wr_ff, rd_ff;
   logic [1:0]    cnt_ff;

   assign full     = (cnt_ff == 2'd2);
   assign empty    = (cnt_ff == 2'd0);
   assign pop_data = mem_ff[rd_ff];

   // entry storage
   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_data;
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wr_ff <= ~wr_ff;
         if (pop)  rd_ff <= ~rd_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

endmodule

`default_nettype wire

// ===== design/sha_back.sv =====
// ----------------------------------------------------------------------------
// sha_back
// one sha-256 round per cycle over queued blocks, then digest word output
// ----------------------------------------------------------------------------
`default_nettype none

module sha_back
   import sha_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire blk_entry_type pop_data,
   input  wire logic          empty,
   output logic               pop,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output logic [31:0]        rsp_digest_word,
   output logic [2:0]         rsp_word_index,
   output logic               rsp_digest_last
);

   typedef enum logic [3:0] {
      B_IDLE  = 4'b0001,
      B_ROUND = 4'b0010,
      B_ADD   = 4'b0100,
      B_OUT   = 4'b1000
   } back_state_type;

   back_state_type                      st_ff;
   logic [HashWords-1:0][WordBits-1:0]  hv_ff;
   logic [HashWords-1:0][WordBits-1:0]  wv_ff;
   logic [BlockWords-1:0][WordBits-1:0] win_ff;
   logic [5:0]                          rnd_ff;
   logic                                fin_ff;
   logic [2:0]                          oidx_ff;
   logic                                ovalid_ff;
   logic [31:0]                         oword_ff;
   logic [2:0]                          oindex_ff;
   logic                                olast_ff;

   word_type w_new, w_cur, t1, t2, ch, maj;
   logic     slot_free;

   // message schedule and round function
   always_comb begin
      w_new = small_sigma1(win_ff[14]) + win_ff[9] + small_sigma0(win_ff[1]) + win_ff[0];
      w_cur = (rnd_ff < 6'd16) ? win_ff[0] : w_new;
      ch    = (wv_ff[4] & wv_ff[5]) ^ (~wv_ff[4] & wv_ff[6]);
      maj   = (wv_ff[0] & wv_ff[1]) ^ (wv_ff[0] & wv_ff[2]) ^ (wv_ff[1] & wv_ff[2]);
      t1    = wv_ff[7] + big_sigma1(wv_ff[4]) + ch + RoundK[rnd_ff] + w_cur;
      t2    = big_sigma0(wv_ff[0]) + maj;
   end

   assign pop       = (st_ff == B_IDLE) && !empty;
   assign slot_free = !ovalid_ff || !rsp_stall;

   // compression sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff     <= B_IDLE;
         hv_ff     <= InitHash;
         rnd_ff    <= 6'd0;
         oidx_ff   <= 3'd0;
         ovalid_ff <= 1'b0;
      end else begin
         if (slot_free) ovalid_ff <= 1'b0;
         unique case (st_ff)
            B_IDLE: begin
               if (!empty) begin
                  win_ff <= pop_data.words;
                  fin_ff <= pop_data.is_final;
                  wv_ff  <= hv_ff;
                  rnd_ff <= 6'd0;
                  st_ff  <= B_ROUND;
               end
            end
            B_ROUND: begin
               win_ff <= {w_cur, win_ff[BlockWords-1:1]};
               wv_ff  <= {wv_ff[6:4], wv_ff[3] + t1, wv_ff[2:0], t1 + t2};
               rnd_ff <= rnd_ff + 6'd1;
               if (rnd_ff == 6'd63) st_ff <= B_ADD;
            end
            B_ADD: begin
               for (int i = 0; i < HashWords; i++) hv_ff[i] <= hv_ff[i] + wv_ff[i];
               oidx_ff <= 3'd0;
               st_ff   <= fin_ff ? B_OUT : B_IDLE;
            end
            B_OUT: begin
               if (slot_free) begin
                  ovalid_ff <= 1'b1;
                  oword_ff  <= hv_ff[oidx_ff];
                  oindex_ff <= oidx_ff;
                  olast_ff  <= (oidx_ff == 3'd7);
                  oidx_ff   <= oidx_ff + 3'd1;
                  if (oidx_ff == 3'd7) begin
                     hv_ff <= InitHash;
                     st_ff <= B_IDLE;
                  end
               end
            end
            default: st_ff <= B_IDLE;
         endcase
      end
   end

   assign rsp_valid       = ovalid_ff;
   assign rsp_digest_word = oword_ff;
   assign rsp_word_index  = oindex_ff;
   assign rsp_digest_last = olast_ff;

endmodule

`default_nettype wire

// ===== design/sha256_hash_engine_unit.sv =====
// ----------------------------------------------------------------------------
// sha256_hash_engine_unit
// streaming sha-256 engine: big-endian words in, eight digest words out
// ----------------------------------------------------------------------------
// Each input word is accepted, its valid bytes are then packed one at a time
// and a closing step follows in the byte packer. A last word adds a padding
// step and a length step, and every finished block adds a push step that
// waits while the queue is full. Each full 64-byte block then passes through
// the single round unit (load, 64 rounds, hash add). The byte packer takes no
// new word until it is done with the last one; a two-block queue lets packing
// continue while a block compresses. The digest leaves as eight transfers, H0
// first, one per cycle while rsp_stall is low.
`default_nettype none

module sha256_hash_engine_unit
   import sha_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [31:0] req_data_word,
   input  wire logic [2:0]  req_byte_count,
   input  wire logic        req_last,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_digest_word,
   output logic [2:0]       rsp_word_index,
   output logic             rsp_digest_last
);

   blk_entry_type push_data, pop_data;
   logic          push, pop, full, empty;

   // byte packer and padding
   sha_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_data_word, .req_byte_count,
      .req_last, .push, .push_data, .full
   );

   // block queue
   sha_fifo u_fifo (
      .clock, .reset, .push, .push_data, .full, .pop, .pop_data, .empty
   );

   // compression and digest output
   sha_back u_back (
      .clock, .reset, .pop_data, .empty, .pop, .rsp_valid, .rsp_stall,
      .rsp_digest_word, .rsp_word_index, .rsp_digest_last
   );

endmodule

`default_nettype wire

// ===== design/sha_checker.sv =====
// ----------------------------------------------------------------------------
// sha_checker
// port-level checks on the digest output sequence
// ----------------------------------------------------------------------------
`default_nettype none

module sha_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [31:0] rsp_digest_word,
   input wire logic [2:0]  rsp_word_index,
   input wire logic        rsp_digest_last
);

   // last flag only on the eighth word
   a_last_idx: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_digest_last == (rsp_word_index == 3'd7)))
      else $error("digest_last does not match word index");

   // digest words follow one another without gaps
   a_next_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_digest_last) |=>
      (rsp_valid && rsp_word_index == $past(rsp_word_index) + 3'd1))
      else $error("digest word sequence broken");

   // stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_digest_word)))
      else $error("stalled digest word changed");

   // nothing comes out right after reset
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind sha256_hash_engine_unit sha_checker u_checker (
   .clock, .reset, .rsp_valid, .rsp_stall, .rsp_digest_word, .rsp_word_index,
   .rsp_digest_last
);

`default_nettype wire

// ===== dv/sha256_hash_engine_unit_test.sv =====
// ----------------------------------------------------------------------------
// sha256_hash_engine_unit_test
// drives messages of random length and byte packing through the sha-256
// engine and compares each digest word with a software digest model
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

// expected digest words plus a running model of the hash state
class digest_scoreboard;
   logic [31:0] hash_state [8];
   logic [31:0] block_buf [16];
   int unsigned block_fill;
   logic [63:0] bit_length;
   logic [31:0] digest_queue [$];
   int unsigned mismatches;
   int unsigned words_checked;
   int unsigned digests_done;

   function new();
      start_message();
      mismatches = 0;
      words_checked = 0;
      digests_done = 0;
   endfunction

   function void start_message();
      for (int i = 0; i < 8; i++) hash_state[i] = sha_pkg::InitHash[i];
      for (int i = 0; i < 16; i++) block_buf[i] = '0;
      block_fill = 0;
      bit_length = '0;
   endfunction

   function automatic logic [31:0] ror(logic [31:0] v, int s);
      return (v >> s) | (v << (32 - s));
   endfunction

   // 64 rounds over the buffered block, then clear the buffer
   function void compress();
      logic [31:0] w [64];
      logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
      for (int t = 0; t < 16; t++) w[t] = block_buf[t];
      for (int t = 16; t < 64; t++)
         w[t] = (ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10)) + w[t-7]
              + (ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3)) + w[t-16];
      a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
      e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
      for (int t = 0; t < 64; t++) begin
         t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
            + sha_pkg::RoundK[t] + w[t];
         t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
         h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
      end
      hash_state[0] += a; hash_state[1] += b; hash_state[2] += c;
      hash_state[3] += d; hash_state[4] += e; hash_state[5] += f;
      hash_state[6] += g; hash_state[7] += h;
      for (int i = 0; i < 16; i++) block_buf[i] = '0;
      block_fill = 0;
   endfunction

   function void add_byte(logic [7:0] b);
      block_buf[block_fill >> 2] |= 32'(b) << ((3 - (block_fill & 3)) * 8);
      block_fill++;
      if (block_fill == 64) compress();
   endfunction

   // note an accepted input transfer
   function void note_input(logic [31:0] data, logic [2:0] count, logic last);
      int n;
      n = (count > 4) ? 4 : count;
      for (int i = 0; i < n; i++) begin
         add_byte(data[(3 - i) * 8 +: 8]);
         bit_length += 8;
      end
      if (last) begin
         add_byte(sha_pkg::PadByte);
         while (block_fill != 56) add_byte(8'h00);
         block_buf[14] = bit_length[63:32];
         block_buf[15] = bit_length[31:0];
         compress();
         for (int i = 0; i < 8; i++)
            digest_queue.insert(digest_queue.size(), hash_state[i]);
         start_message();
      end
   endfunction

   // check one result transfer against the oldest expected word
   function void check_result(logic [31:0] word, logic [2:0] idx, logic dlast);
      logic [31:0] exp_word;
      logic [2:0] exp_idx;
      if (digest_queue.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected digest transfer word=%h idx=%0d", word, idx);
         return;
      end
      exp_idx = 3'(7 - ((digest_queue.size() - 1) % 8));
      exp_word = digest_queue.pop_front();
      words_checked++;
      if (dlast) digests_done++;
      if (word !== exp_word || idx !== exp_idx || dlast !== (exp_idx == 3'd7)) begin
         mismatches++;
         if (mismatches <= 10)
            $display("digest mismatch: exp %h/%0d/%0d got %h/%0d/%0d",
                     exp_word, exp_idx, exp_idx == 3'd7, word, idx, dlast);
      end
   endfunction
endclass

module sha256_hash_engine_unit_test;
   localparam int unsigned CycleLimit = 1500000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [31:0] req_data_word = '0;
   logic [2:0] req_byte_count = '0;
   logic req_last = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b1;
   logic [31:0] rsp_digest_word;
   logic [2:0] rsp_word_index;
   logic rsp_digest_last;

   digest_scoreboard board = new();
   int unsigned cycle_count = 0;
   bit send_done = 1'b0;
   bit holdoff_active = 1'b0;
   int unsigned items_sent = 0;

   sha256_hash_engine_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_data_word(req_data_word), .req_byte_count(req_byte_count),
      .req_last(req_last),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_digest_word(rsp_digest_word), .rsp_word_index(rsp_word_index),
      .rsp_digest_last(rsp_digest_last)
   );

   always #5 clock = ~clock;

   // mostly short gaps, a few long ones
   function automatic int unsigned gap_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // offer one input transfer and wait for acceptance
   task automatic send_word(logic [31:0] data, logic [2:0] count, logic last);
      req_valid <= 1'b1;
      req_data_word <= data;
      req_byte_count <= count;
      req_last <= last;
      do @(posedge clock); while (req_stall);
      board.note_input(data, count, last);
      items_sent++;
   endtask

   task automatic idle_req(int unsigned n);
      if (n == 0) return;
      req_valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // one message of random content
   task automatic send_message(int unsigned words, bit tidy);
      logic [2:0] cnt;
      for (int i = 0; i < words; i++) begin
         if (tidy) cnt = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7)) : 3'd4;
         else cnt = 3'($urandom_range(0, 7));
         send_word($urandom, cnt, i == words - 1);
         if ($urandom_range(0, 2) == 0) idle_req(gap_len());
      end
   endtask

   // result side: random stall and a long hold-off while the sender runs
   initial begin
      int unsigned n;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (holdoff_active) rsp_stall <= 1'b1;
         else begin
            n = gap_len();
            rsp_stall <= (n != 0) && ($urandom_range(0, 2) == 0);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid && !rsp_stall)
         board.check_result(rsp_digest_word, rsp_word_index, rsp_digest_last);
      if (cycle_count >= CycleLimit) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // long receiver hold-off, counted in its own process
   initial begin
      wait (items_sent >= 150);
      holdoff_active = 1'b1;
      repeat (3000) @(posedge clock);
      holdoff_active = 1'b0;
   end

   initial begin
      int unsigned len;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: empty message, field extremes, short words, padding edges
      send_word(32'h0, 3'd0, 1'b1);
      send_word(32'h61626300, 3'd3, 1'b1);
      send_word(32'hffffffff, 3'd4, 1'b0);
      send_word(32'h12345678, 3'd0, 1'b0);
      send_word(32'h00000000, 3'd7, 1'b0);
      send_word(32'hdeadbeef, 3'd1, 1'b0);
      send_word(32'hcafef00d, 3'd2, 1'b0);
      send_word(32'ha5a5a5a5, 3'd5, 1'b0);
      send_word(32'h5a5a5a5a, 3'd6, 1'b1);
      for (int i = 0; i < 14; i++) send_word($urandom, 3'd4, i == 13);
      send_word(32'hffffffff, 3'd4, 1'b1);
      for (int i = 0; i < 16; i++) send_word(~32'(i), 3'd4, i == 15);
      // random: mostly well-formed messages, some odd byte counts
      while (items_sent < 420) begin
         len = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 34)
                                           : $urandom_range(1, 12);
         send_message(len, $urandom_range(0, 3) != 0);
         idle_req(gap_len());
      end
      req_valid <= 1'b0;
      send_done = 1'b1;
      wait (board.digest_queue.size() == 0);
      repeat (300) @(posedge clock);
      $display("sent %0d input words, checked %0d digest words over %0d digests",
               items_sent, board.words_checked, board.digests_done);
      if (board.mismatches == 0 && board.digest_queue.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d mismatches", board.mismatches);
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule

`default_nettype wire

// ===== filelist.f =====
design/sha_pkg.sv
design/sha_front.sv
design/sha_fifo.sv
design/sha_back.sv
design/sha256_hash_engine_unit.sv
design/sha_checker.sv
dv/sha256_hash_engine_unit_test.sv
